// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// concurrent assertion shorthands, sampled on clk and held off during reset
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge out of reset
`define ASSERT_ALWAYS(label, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (expr)) \
		else $error(msg);

// antecedent implies consequent in the same cycle
`define ASSERT_IMPLY(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

`endif

// ===== rtl/lsia_pkg.sv =====
// ----------------------------------------------------------------------------
// lsia_pkg
// types, codes and helpers of the lfsr sequenced id allocator
// ----------------------------------------------------------------------------
`default_nettype none

package lsia_pkg;

	localparam int ID_W    = 10;
	localparam int CNT_W   = 11;
	localparam int POOL_SIZE = 1 << ID_W;

	localparam logic [ID_W-1:0]  ID_MAX     = ID_W'(POOL_SIZE - 1);
	localparam logic [CNT_W-1:0] POOL_LIMIT = CNT_W'(POOL_SIZE - 1);
	localparam logic [ID_W-1:0]  SEQ_SEED   = 10'h1bc;
	localparam int               SEQ_TOP    = 9;

	localparam logic REQ_ALLOC   = 1'b0;
	localparam logic REQ_RELEASE = 1'b1;

	typedef enum logic [1:0] {
		STAT_OK          = 2'd0,
		STAT_EXHAUSTED   = 2'd1,
		STAT_BAD_RELEASE = 2'd2
	} status_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_SEARCH,
		ST_REL,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic            req_type;
		logic [ID_W-1:0] release_id;
	} req_t;

	typedef struct packed {
		logic [ID_W-1:0] granted_id;
		logic [1:0]      status;
	} rsp_t;

	// fibonacci step for x^10 + x^7 + 1, shifting right
	function automatic logic [ID_W-1:0] seq_next(input logic [ID_W-1:0] s);
		logic fb;
		fb = s[0] ^ s[3];
		return {fb, s[SEQ_TOP:1]};
	endfunction

endpackage

`default_nettype wire

// ===== rtl/lfsr_sequenced_id_allocator.sv =====
// order: a release reads its bitmap entry, then clears it; an exhausted allocation
//   goes to the result at once; others step the lfsr to a free entry, one bitmap read a cycle
// throughput: one item at a time; the next item is taken once the result is
//   handed to the output register, which holds it while the consumer stalls
// reset: a clearing pass zeroes all 1024 bitmap entries, one entry a cycle,
//   with req_stall high; lfsr starts at 0x1bc and the taken count at zero
// ----------------------------------------------------------------------------
// lfsr_sequenced_id_allocator
// hands out ids 1..1023 in lfsr order from a used bitmap and takes them back
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module lfsr_sequenced_id_allocator
	import lsia_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic req_valid,
	output logic      req_stall,
	input  wire req_t req_item,
	output logic      rsp_valid,
	input  wire logic rsp_stall,
	output rsp_t      rsp_item
);

	state_t state_q, state_nxt;

	logic [ID_W-1:0]  seq_q;
	logic [CNT_W-1:0] taken_q;
	logic [ID_W-1:0]  clr_cnt_q;
	logic [ID_W-1:0]  iss_cnt_q;
	logic [ID_W-1:0]  cand_s1;
	logic             cand_vld_s1;
	logic             cand_last_s1;
	logic [ID_W-1:0]  rel_id_q;
	rsp_t             res_q;
	logic             rsp_valid_q;
	rsp_t             rsp_item_q;

	// bitmap memory
	logic             used_mem [POOL_SIZE];
	logic             rd_data_q;
	logic             mem_we, mem_wd, mem_re;
	logic [ID_W-1:0]  mem_wa, mem_ra;

	logic            out_free;
	logic            issue;
	logic            search_stop;
	logic            found;
	logic            rel_ok;
	logic            exhausted;
	logic [ID_W-1:0] seq_nxt;

	assign out_free    = !rsp_valid_q || !rsp_stall;
	assign seq_nxt     = seq_next(seq_q);
	assign found       = cand_vld_s1 && !rd_data_q;
	assign search_stop = cand_vld_s1 && (!rd_data_q || cand_last_s1);
	assign issue       = (iss_cnt_q != ID_MAX) && !search_stop;
	assign rel_ok      = (rel_id_q != '0) && rd_data_q;
	assign exhausted   = taken_q >= POOL_LIMIT;

	always_ff @(posedge clk) begin
		if (mem_we)
			used_mem[mem_wa] <= mem_wd;
		if (mem_re)
			rd_data_q <= used_mem[mem_ra];
	end

	// next state
	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			ST_CLEAR: begin
				if (clr_cnt_q == ID_MAX)
					state_nxt = ST_IDLE;
			end
			ST_IDLE: begin
				if (req_valid) begin
					if (req_item.req_type == REQ_RELEASE)
						state_nxt = ST_REL;
					else if (exhausted)
						state_nxt = ST_DONE;
					else
						state_nxt = ST_SEARCH;
				end
			end
			ST_SEARCH: begin
				if (search_stop)
					state_nxt = ST_DONE;
			end
			ST_REL:  state_nxt = ST_DONE;
			ST_DONE: begin
				if (out_free)
					state_nxt = ST_IDLE;
			end
			default: state_nxt = ST_CLEAR;
		endcase
	end

	// outputs
	always_comb begin
		req_stall = 1'b1;
		mem_we    = 1'b0;
		mem_wd    = 1'b0;
		mem_wa    = clr_cnt_q;
		mem_re    = 1'b0;
		mem_ra    = req_item.release_id;
		unique case (state_q)
			ST_CLEAR: begin
				mem_we = 1'b1;
			end
			ST_IDLE: begin
				req_stall = 1'b0;
				mem_re    = req_valid;
			end
			ST_SEARCH: begin
				mem_re = issue;
				mem_ra = seq_nxt;
				mem_we = found;
				mem_wa = cand_s1;
				mem_wd = 1'b1;
			end
			ST_REL: begin
				mem_we = rel_ok;
				mem_wa = rel_id_q;
			end
			ST_DONE: ;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			seq_q       <= SEQ_SEED;
			taken_q     <= '0;
			clr_cnt_q   <= '0;
			cand_vld_s1 <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (state_q == ST_CLEAR)
				clr_cnt_q <= clr_cnt_q + 1'b1;
			if (state_q == ST_IDLE)
				cand_vld_s1 <= 1'b0;
			if (state_q == ST_SEARCH) begin
				cand_vld_s1 <= issue;
				if (issue)
					seq_q <= seq_nxt;
				if (found) begin
					seq_q   <= cand_s1;
					taken_q <= taken_q + 1'b1;
				end
			end
			if (state_q == ST_REL && rel_ok && taken_q != '0)
				taken_q <= taken_q - 1'b1;
			if (state_q == ST_DONE && out_free)
				rsp_valid_q <= 1'b1;
			else if (!rsp_stall)
				rsp_valid_q <= 1'b0;
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && req_valid) begin
			rel_id_q  <= req_item.release_id;
			iss_cnt_q <= '0;
			res_q     <= '{granted_id: '0, status: STAT_EXHAUSTED};
		end
		if (state_q == ST_SEARCH) begin
			if (issue) begin
				cand_s1      <= seq_nxt;
				cand_last_s1 <= (iss_cnt_q == ID_MAX - 1'b1);
				iss_cnt_q    <= iss_cnt_q + 1'b1;
			end
			if (found)
				res_q <= '{granted_id: cand_s1, status: STAT_OK};
			else
				res_q <= '{granted_id: '0, status: STAT_EXHAUSTED};
		end
		if (state_q == ST_REL) begin
			if (rel_ok)
				res_q <= '{granted_id: '0, status: STAT_OK};
			else
				res_q <= '{granted_id: '0, status: STAT_BAD_RELEASE};
		end
		if (state_q == ST_DONE && out_free)
			rsp_item_q <= res_q;
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp_item  = rsp_item_q;

	`ASSERT_ALWAYS(a_taken_bound, taken_q <= POOL_LIMIT, "taken count above pool limit")
	`ASSERT_IMPLY(a_seq_nonzero, state_q == ST_SEARCH, seq_q != '0, "lfsr reached zero")
	`ASSERT_IMPLY(a_clear_stalls, state_q == ST_CLEAR, req_stall, "item taken during clear")
	`ASSERT_IMPLY(a_grant_ok, rsp_valid && rsp_item.granted_id != '0,
		rsp_item.status == STAT_OK, "nonzero id with error status")

endmodule

`default_nettype wire

// ===== tb/sv/lfsr_sequenced_id_allocator_tb.sv =====
// ----------------------------------------------------------------------------
// lfsr_sequenced_id_allocator_tb
// table of directed allocate and release items, then random traffic that fills
// the pool to exhaustion; every result is checked against the table or a bitmap and lfsr
// predictor, with random gaps on both sides
// ----------------------------------------------------------------------------
module lfsr_sequenced_id_allocator_tb;
	import lsia_pkg::*;

	localparam int CYCLE_LIMIT = 12_000_000;
	localparam int SETTLE_CYCLES = 40;
	localparam int MIX_ITEMS = 120;
	localparam int FULL_MIX_ITEMS = 80;
	localparam int OVERFLOW_ALLOCS = 6;

	typedef struct {
		req_t item;
		bit   typed;
		rsp_t want;
	} dir_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_stall;
	req_t req_item = '0;
	logic rsp_valid;
	logic rsp_stall = 1'b0;
	rsp_t rsp_item;

	// predictor state
	logic            id_taken [POOL_SIZE];
	logic [ID_W-1:0] lfsr_state;
	logic [CNT_W-1:0] taken_total;
	logic [ID_W-1:0] held_ids [$];

	rsp_t pending_answers [$];
	int   error_total = 0;
	int   cycle_total = 0;
	int   send_idle_pct = 33;
	int   rsp_idle_pct = 68;

	dir_row_t opening_rows [14] = '{
		'{'{REQ_RELEASE, 10'd0},     1'b1, '{10'd0, STAT_BAD_RELEASE}},
		'{'{REQ_RELEASE, ID_MAX},    1'b1, '{10'd0, STAT_BAD_RELEASE}},
		'{'{REQ_RELEASE, 10'd1},     1'b1, '{10'd0, STAT_BAD_RELEASE}},
		'{'{REQ_ALLOC,   10'd0},     1'b1, '{10'h2de, STAT_OK}},
		'{'{REQ_ALLOC,   ID_MAX},    1'b1, '{10'h36f, STAT_OK}},
		'{'{REQ_RELEASE, 10'h2de},   1'b1, '{10'd0, STAT_OK}},
		'{'{REQ_RELEASE, 10'h2de},   1'b1, '{10'd0, STAT_BAD_RELEASE}},
		'{'{REQ_ALLOC,   10'h155},   1'b0, '{10'd0, STAT_OK}},
		'{'{REQ_ALLOC,   10'h2aa},   1'b0, '{10'd0, STAT_OK}},
		'{'{REQ_RELEASE, 10'h36f},   1'b1, '{10'd0, STAT_OK}},
		'{'{REQ_ALLOC,   ID_MAX},    1'b0, '{10'd0, STAT_OK}},
		'{'{REQ_RELEASE, 10'd0},     1'b1, '{10'd0, STAT_BAD_RELEASE}},
		'{'{REQ_ALLOC,   10'd0},     1'b0, '{10'd0, STAT_OK}},
		'{'{REQ_RELEASE, 10'h200},   1'b0, '{10'd0, STAT_OK}}
	};

	lfsr_sequenced_id_allocator i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req_item  (req_item),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp_item  (rsp_item)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	function automatic rsp_t predict_answer(input req_t it);
		rsp_t ans;
		int   steps;
		int   k;
		logic found;
		ans.granted_id = '0;
		ans.status = STAT_OK;
		found = 1'b0;
		if (it.req_type == REQ_ALLOC) begin
			if (taken_total >= POOL_LIMIT) begin
				ans.status = STAT_EXHAUSTED;
			end else begin
				for (steps = 0; steps < POOL_LIMIT && !found; steps++) begin
					lfsr_state = {lfsr_state[0] ^ lfsr_state[3], lfsr_state[ID_W-1:1]};
					found = !id_taken[lfsr_state];
				end
				if (found) begin
					id_taken[lfsr_state] = 1'b1;
					taken_total = taken_total + 1'b1;
					ans.granted_id = lfsr_state;
					held_ids.insert(held_ids.size(), lfsr_state);
				end else begin
					ans.status = STAT_EXHAUSTED;
				end
			end
		end else if (it.release_id == '0 || !id_taken[it.release_id]) begin
			ans.status = STAT_BAD_RELEASE;
		end else begin
			id_taken[it.release_id] = 1'b0;
			if (taken_total != '0)
				taken_total = taken_total - 1'b1;
			for (k = 0; k < held_ids.size(); k++) begin
				if (held_ids[k] == it.release_id) begin
					held_ids.delete(k);
					break;
				end
			end
		end
		return ans;
	endfunction

	// an allocation with alloc_pct percent chance, else a release of a held id, of zero, the top id or any id
	function automatic req_t pick_mixed(input int alloc_pct);
		req_t it;
		int   dice;
		dice = $urandom_range(99);
		it.release_id = ID_W'($urandom);
		if (dice < alloc_pct) begin
			it.req_type = REQ_ALLOC;
		end else begin
			it.req_type = REQ_RELEASE;
			if (dice < 90 && held_ids.size() != 0)
				it.release_id = held_ids[$urandom_range(held_ids.size() - 1)];
			else if (dice < 94)
				it.release_id = '0;
			else if (dice < 97)
				it.release_id = ID_MAX;
		end
		return it;
	endfunction

	task automatic send_item(input req_t it, input bit typed, input rsp_t want);
		rsp_t got;
		while ($urandom_range(99) < send_idle_pct) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		req_valid <= 1'b1;
		req_item <= it;
		@(posedge clk);
		while (req_stall)
			@(posedge clk);
		got = predict_answer(it);
		pending_answers.insert(pending_answers.size(), typed ? want : got);
	endtask

	always @(posedge clk) begin
		rsp_t want;
		if (arst_n && rsp_valid && !rsp_stall) begin
			if (pending_answers.size() == 0) begin
				$display("%0t unexpected item: granted_id %h status %0d", $time,
					rsp_item.granted_id, rsp_item.status);
				error_total++;
			end else begin
				want = pending_answers.pop_front();
				if (rsp_item.granted_id !== want.granted_id) begin
					$display("%0t granted_id expected %h actual %h", $time,
						want.granted_id, rsp_item.granted_id);
					error_total++;
				end
				if (rsp_item.status !== want.status) begin
					$display("%0t status expected %0d actual %0d", $time,
						want.status, rsp_item.status);
					error_total++;
				end
			end
		end
		rsp_stall <= ($urandom_range(99) < rsp_idle_pct);
	end

	always @(posedge clk) begin
		cycle_total <= cycle_total + 1;
		if (cycle_total == CYCLE_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

	initial begin
		int r;
		for (r = 0; r < POOL_SIZE; r++)
			id_taken[r] = 1'b0;
		lfsr_state = SEQ_SEED;
		taken_total = '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (r = 0; r < $size(opening_rows); r++)
			send_item(opening_rows[r].item, opening_rows[r].typed, opening_rows[r].want);
		for (r = 0; r < MIX_ITEMS; r++)
			send_item(pick_mixed(55), 1'b0, '0);

		send_idle_pct = 68;
		rsp_idle_pct = 33;
		for (r = 0; r < MIX_ITEMS; r++)
			send_item(pick_mixed(55), 1'b0, '0);

		// fill the pool, run past exhaustion, then churn while nearly full
		send_idle_pct = 0;
		rsp_idle_pct = 0;
		while (taken_total < POOL_LIMIT)
			send_item('{REQ_ALLOC, ID_W'($urandom)}, 1'b0, '0);
		for (r = 0; r < OVERFLOW_ALLOCS; r++)
			send_item('{REQ_ALLOC, ID_W'($urandom)}, 1'b0, '0);
		for (r = 0; r < FULL_MIX_ITEMS; r++)
			send_item(pick_mixed(50), 1'b0, '0);
		req_valid <= 1'b0;

		while (pending_answers.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (error_total == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
